// File: sv/three_wire_serial_master_defines.svh
// Assertion macros shared by the three-wire serial master RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef THREE_WIRE_SERIAL_MASTER_DEFINES_SVH
`define THREE_WIRE_SERIAL_MASTER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TWS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/tws_pkg.sv
// Shared types and constants for the three-wire serial master.
// No dependencies; imported by every module of the block.
`default_nettype none

package tws_pkg;

  localparam int READ_BITS_DEF = 32;
  localparam int BYTE_BITS     = 8;
  localparam int KEYS_W        = 32;
  localparam int HALF_W        = 8;

  localparam logic [7:0] READ_CMD = 8'h42;
  localparam logic [HALF_W-1:0] HALF_RESET = 8'd1;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_PARK  = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_PRE  = 3'd1,
    PH_SLO  = 3'd2,
    PH_SHI  = 3'd3,
    PH_RLO  = 3'd4,
    PH_RHI  = 3'd5,
    PH_POST = 3'd6
  } phase_t;

  typedef struct packed {
    logic              clk_level;
    logic              dio_level;
    logic              dio_drive;
    logic              strobe_level;
    logic              busy;
    logic              keys_valid;
    logic [KEYS_W-1:0] keys;
  } tws_res_t;

endpackage

`default_nettype wire

// File: sv/tws_seq.sv
// Transfer sequencer of the three-wire serial master: phase, counters, shifters, line levels.
// Depends on tws_pkg. Advances one tick whenever step_en is high.
`default_nettype none

module tws_seq #(
  parameter int READ_BITS = tws_pkg::READ_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step_en,
  input  logic [1:0]                  action,
  input  logic [7:0]                  cmd_byte,
  input  logic                        dio_sample,
  input  logic [tws_pkg::HALF_W-1:0]  half_period,
  output tws_pkg::tws_res_t           res
);
  import tws_pkg::*;

  localparam int CNT_W = $clog2(READ_BITS + 1);

  phase_t                phase, phase_next;
  logic [CNT_W-1:0]      bit_count, bit_count_next;
  logic [HALF_W-1:0]     delay_count, delay_count_next;
  logic [7:0]            out_shift, out_shift_next;
  logic [READ_BITS-1:0]  key_capture, key_capture_next;
  logic                  reading, reading_next;
  logic                  clk_l, clk_l_next;
  logic                  dio_l, dio_l_next;
  logic                  drv_l, drv_l_next;
  logic                  stb_l, stb_l_next;

  logic [HALF_W-1:0]     reload;
  logic [CNT_W-1:0]      bit_inc;
  logic                  start_shift;
  logic [7:0]            shift_byte;
  logic                  keys_valid_next;

  // A zero half period behaves like one tick.
  assign reload  = (half_period == '0) ? '0 : half_period - 1'b1;
  assign bit_inc = bit_count + 1'b1;

  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    delay_count_next = delay_count;
    out_shift_next   = out_shift;
    key_capture_next = key_capture;
    reading_next     = reading;
    clk_l_next       = clk_l;
    dio_l_next       = dio_l;
    drv_l_next       = drv_l;
    stb_l_next       = stb_l;
    start_shift      = 1'b0;
    shift_byte       = cmd_byte;
    keys_valid_next  = 1'b0;

    if (phase == PH_IDLE) begin
      unique case (action)
        ACT_WRITE: begin
          reading_next = 1'b0;
          stb_l_next   = 1'b0;
          start_shift  = 1'b1;
        end
        ACT_READ: begin
          reading_next     = 1'b1;
          key_capture_next = '0;
          stb_l_next       = 1'b0;
          drv_l_next       = 1'b1;
          phase_next       = PH_PRE;
          delay_count_next = reload;
        end
        ACT_PARK: begin
          clk_l_next = 1'b1;
          stb_l_next = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (delay_count != '0) begin
      delay_count_next = delay_count - 1'b1;
    end else begin
      unique case (phase)
        PH_PRE: begin
          start_shift = 1'b1;
          shift_byte  = READ_CMD;
        end
        PH_SLO: begin
          clk_l_next       = 1'b1;
          phase_next       = PH_SHI;
          delay_count_next = reload;
        end
        PH_SHI: begin
          bit_count_next = bit_inc;
          if (bit_inc < CNT_W'(BYTE_BITS)) begin
            out_shift_next   = {1'b0, out_shift[7:1]};
            clk_l_next       = 1'b0;
            dio_l_next       = out_shift[1];
            phase_next       = PH_SLO;
            delay_count_next = reload;
          end else if (reading) begin
            dio_l_next       = 1'b0;
            drv_l_next       = 1'b0;
            clk_l_next       = 1'b0;
            bit_count_next   = '0;
            phase_next       = PH_RLO;
            delay_count_next = reload;
          end else begin
            stb_l_next = 1'b1;
            phase_next = PH_IDLE;
          end
        end
        PH_RLO: begin
          // Bits arrive LSB first; after READ_BITS shifts the first lands in bit 0.
          clk_l_next       = 1'b1;
          key_capture_next = {dio_sample, key_capture[READ_BITS-1:1]};
          phase_next       = PH_RHI;
          delay_count_next = reload;
        end
        PH_RHI: begin
          bit_count_next = bit_inc;
          if (bit_inc < CNT_W'(READ_BITS)) begin
            clk_l_next = 1'b0;
            phase_next = PH_RLO;
          end else begin
            stb_l_next = 1'b1;
            phase_next = PH_POST;
          end
          delay_count_next = reload;
        end
        PH_POST: begin
          keys_valid_next = 1'b1;
          reading_next    = 1'b0;
          phase_next      = PH_IDLE;
        end
        default: begin
        end
      endcase
    end

    if (start_shift) begin
      out_shift_next   = shift_byte;
      bit_count_next   = '0;
      clk_l_next       = 1'b0;
      drv_l_next       = 1'b1;
      dio_l_next       = shift_byte[0];
      phase_next       = PH_SLO;
      delay_count_next = reload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= '0;
      delay_count <= '0;
      out_shift   <= '0;
      key_capture <= '0;
      reading     <= 1'b0;
      clk_l       <= 1'b1;
      stb_l       <= 1'b1;
      dio_l       <= 1'b0;
      drv_l       <= 1'b1;
    end else if (step_en) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      delay_count <= delay_count_next;
      out_shift   <= out_shift_next;
      key_capture <= key_capture_next;
      reading     <= reading_next;
      clk_l       <= clk_l_next;
      stb_l       <= stb_l_next;
      dio_l       <= dio_l_next;
      drv_l       <= drv_l_next;
    end
  end

  always_comb begin
    res.clk_level    = clk_l_next;
    res.dio_level    = dio_l_next;
    res.dio_drive    = drv_l_next;
    res.strobe_level = stb_l_next;
    res.busy         = (phase_next != PH_IDLE);
    res.keys_valid   = keys_valid_next;
    res.keys         = keys_valid_next ? KEYS_W'(key_capture) : '0;
  end

endmodule

`default_nettype wire

// File: sv/three_wire_serial_master.sv
// Three-wire serial master top level: input register, sequencer, result register.
// Items pass the input register and the result register; one item per cycle while the
// receiver does not stall, bounded only by the result register, refilled as it drains.
// Reset (rst, synchronous) empties both registers, idles the sequencer with clock and
// strobe high and data driven low, and loads a half period of one tick.
`default_nettype none

module three_wire_serial_master #(
  parameter int READ_BITS = tws_pkg::READ_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // Item input channel.
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 action,
  input  logic [7:0]                 cmd_byte,
  input  logic                       dio_sample,
  // Result channel.
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       clk_level,
  output logic                       dio_level,
  output logic                       dio_drive,
  output logic                       strobe_level,
  output logic                       busy_res,
  output logic                       keys_valid,
  output logic [tws_pkg::KEYS_W-1:0] keys,
  // Configuration write: half period in ticks.
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tws_pkg::HALF_W-1:0] cfg_data
);
  import tws_pkg::*;

  `include "three_wire_serial_master_defines.svh"

  // Input register. It holds one item until the sequencer can step on it.
  logic        inq_valid;
  logic [1:0]  inq_action;
  logic [7:0]  inq_cmd_byte;
  logic        inq_dio_sample;

  logic              out_valid_q;
  tws_res_t          res_q;
  tws_res_t          res_next;
  logic [HALF_W-1:0] half_period;
  logic              step;
  logic              in_take;

  // The sequencer advances when an item waits and the result register is free
  // or being emptied in this same cycle.
  assign step     = inq_valid && (!out_valid_q || !out_stall);
  assign in_stall = inq_valid && !step;
  assign in_take  = in_valid && !in_stall;

  // The register may be rewritten at any time; the user must write it only while idle, the block does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      half_period <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_take) begin
      inq_valid <= 1'b1;
    end else if (step) begin
      inq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      inq_action     <= action;
      inq_cmd_byte   <= cmd_byte;
      inq_dio_sample <= dio_sample;
    end
  end

  tws_seq #(
    .READ_BITS (READ_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .step_en     (step),
    .action      (inq_action),
    .cmd_byte    (inq_cmd_byte),
    .dio_sample  (inq_dio_sample),
    .half_period (half_period),
    .res         (res_next)
  );

  // Result register. It holds its item while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res_next;
    end
  end

  assign out_valid    = out_valid_q;
  assign clk_level    = res_q.clk_level;
  assign dio_level    = res_q.dio_level;
  assign dio_drive    = res_q.dio_drive;
  assign strobe_level = res_q.strobe_level;
  assign busy_res     = res_q.busy;
  assign keys_valid   = res_q.keys_valid;
  assign keys         = res_q.keys;

  // The key word is reported only alongside its valid pulse.
  `TWS_ASSERT_IMP(a_keys_zero_idle, clk, rst, out_valid_q && !res_q.keys_valid, res_q.keys == '0, "keys nonzero without keys_valid")

  // A completed read has already raised strobe and left the busy state.
  `TWS_ASSERT_IMP(a_valid_ends_read, clk, rst, out_valid_q && res_q.keys_valid, res_q.strobe_level && !res_q.busy, "keys_valid while transfer still open")

  // Strobe is low only while a transfer is in progress.
  `TWS_ASSERT_IMP(a_strobe_low_busy, clk, rst, out_valid_q && !res_q.strobe_level, res_q.busy, "strobe low while idle")

  // A released data line always carries a low level underneath.
  `TWS_ASSERT_IMP(a_released_low, clk, rst, out_valid_q && !res_q.dio_drive, !res_q.dio_level, "data level high while released")

endmodule

`default_nettype wire

// File: dv/tws_link_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the three-wire serial master: watches the item, result and config
// channels, predicts every line state with its own sequencer copy and compares.
// Depends on tws_pkg for the action codes, phase encoding and the result struct.

module tws_link_checker
  import tws_pkg::*;
#(
  parameter int READ_BITS = READ_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        action,
  input  logic [7:0]        cmd_byte,
  input  logic              dio_sample,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              clk_level,
  input  logic              dio_level,
  input  logic              dio_drive,
  input  logic              strobe_level,
  input  logic              busy_res,
  input  logic              keys_valid,
  input  logic [KEYS_W-1:0] keys,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [HALF_W-1:0] cfg_data,
  output int                fail_count,
  output int                outstanding,
  output logic              seq_active
);

  // Predicted sequencer state.
  phase_t            phase;
  logic [5:0]        bit_cnt;
  logic [7:0]        dly;
  logic [7:0]        shift_r;
  logic [HALF_W-1:0] half_r;
  logic [KEYS_W-1:0] capture;
  logic              reading;
  logic              clk_l, dio_l, drv_l, stb_l;

  tws_res_t line_q[$];

  function automatic logic [7:0] reload_val();
    return (half_r == '0) ? 8'd0 : half_r - 8'd1;
  endfunction

  task automatic load_shift(input logic [7:0] b);
    shift_r = b;
    bit_cnt = '0;
    clk_l   = 1'b0;
    drv_l   = 1'b1;
    dio_l   = b[0];
    phase   = PH_SLO;
    dly     = reload_val();
  endtask

  task automatic advance_link(input logic [1:0] act, input logic [7:0] cmd,
                              input logic samp, output tws_res_t r);
    logic              pulse;
    logic [KEYS_W-1:0] word;
    pulse = 1'b0;
    word  = '0;
    if (phase == PH_IDLE) begin
      case (act)
        ACT_WRITE: begin
          reading = 1'b0;
          stb_l   = 1'b0;
          load_shift(cmd);
        end
        ACT_READ: begin
          reading = 1'b1;
          capture = '0;
          stb_l   = 1'b0;
          drv_l   = 1'b1;
          phase   = PH_PRE;
          dly     = reload_val();
        end
        ACT_PARK: begin
          clk_l = 1'b1;
          stb_l = 1'b1;
        end
        default: ;
      endcase
    end else if (dly != 8'd0) begin
      dly = dly - 8'd1;
    end else begin
      case (phase)
        PH_PRE: load_shift(READ_CMD);
        PH_SLO: begin
          clk_l = 1'b1;
          phase = PH_SHI;
          dly   = reload_val();
        end
        PH_SHI: begin
          bit_cnt = bit_cnt + 6'd1;
          if (bit_cnt < BYTE_BITS) begin
            shift_r = shift_r >> 1;
            clk_l   = 1'b0;
            dio_l   = shift_r[0];
            phase   = PH_SLO;
            dly     = reload_val();
          end else if (reading) begin
            // Byte sent: release the data line and start clocking the keys in.
            dio_l   = 1'b0;
            drv_l   = 1'b0;
            clk_l   = 1'b0;
            bit_cnt = '0;
            phase   = PH_RLO;
            dly     = reload_val();
          end else begin
            stb_l = 1'b1;
            phase = PH_IDLE;
          end
        end
        PH_RLO: begin
          clk_l = 1'b1;
          if (bit_cnt < KEYS_W) capture = capture | (KEYS_W'(samp) << bit_cnt);
          phase = PH_RHI;
          dly   = reload_val();
        end
        PH_RHI: begin
          bit_cnt = bit_cnt + 6'd1;
          if (bit_cnt < READ_BITS) begin
            clk_l = 1'b0;
            phase = PH_RLO;
          end else begin
            stb_l = 1'b1;
            phase = PH_POST;
          end
          dly = reload_val();
        end
        default: begin
          pulse   = 1'b1;
          word    = capture;
          reading = 1'b0;
          phase   = PH_IDLE;
        end
      endcase
    end
    r = {clk_l, dio_l, drv_l, stb_l, phase != PH_IDLE, pulse, word};
  endtask

  task automatic cmp_field(input string f, input logic [KEYS_W-1:0] e,
                           input logic [KEYS_W-1:0] a, inout bit bad);
    if (e !== a) begin
      $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, f, e, a);
      bad = 1'b1;
    end
  endtask

  always @(posedge clk) begin : watch
    tws_res_t want;
    tws_res_t got;
    bit       bad;
    bad = 1'b0;
    if (rst) begin
      phase   = PH_IDLE;
      bit_cnt = '0;
      dly     = '0;
      shift_r = '0;
      half_r  = HALF_RESET;
      capture = '0;
      reading = 1'b0;
      clk_l   = 1'b1;
      stb_l   = 1'b1;
      dio_l   = 1'b0;
      drv_l   = 1'b1;
      line_q.delete();
      fail_count  <= 0;
      outstanding <= 0;
      seq_active  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) half_r = cfg_data;
      // Results are checked before this edge's item is queued, so a spurious
      // result can never be matched against an item accepted in the same cycle.
      if (out_valid && !out_stall) begin
        got = {clk_level, dio_level, dio_drive, strobe_level, busy_res, keys_valid, keys};
        if (line_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual %0h", $time, got);
          bad = 1'b1;
        end else begin
          want = line_q.pop_front();
          cmp_field("clk_level", want.clk_level, got.clk_level, bad);
          cmp_field("dio_level", want.dio_level, got.dio_level, bad);
          cmp_field("dio_drive", want.dio_drive, got.dio_drive, bad);
          cmp_field("strobe_level", want.strobe_level, got.strobe_level, bad);
          cmp_field("busy_res", want.busy, got.busy, bad);
          cmp_field("keys_valid", want.keys_valid, got.keys_valid, bad);
          cmp_field("keys", want.keys, got.keys, bad);
        end
      end
      if (in_valid && !in_stall) begin
        advance_link(action, cmd_byte, dio_sample, want);
        line_q.push_back(want);
      end
      if (bad) fail_count <= fail_count + 1;
      outstanding <= line_q.size();
      seq_active  <= (phase != PH_IDLE);
    end
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Top of the three-wire serial master testbench: clock, reset, item and config stimulus,
// result back-pressure, final verdict. Depends on tws_pkg, the master and tws_link_checker.

module tb_top;
  import tws_pkg::*;

  // The slowest correct run is about two thousand items plus one long receiver hold;
  // this limit leaves a wide margin above that.
  localparam int LIMIT     = 400000;
  localparam int LONG_HOLD = 400;

  // How the data line is modeled while a transfer is being ticked along.
  typedef enum int {SAMP_LOW, SAMP_HIGH, SAMP_RAND} samp_mode_t;

  logic                clk;
  logic                rst          = 1'b1;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [1:0]          action       = ACT_TICK;
  logic [7:0]          cmd_byte     = 8'h00;
  logic                dio_sample   = 1'b0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic                clk_level;
  logic                dio_level;
  logic                dio_drive;
  logic                strobe_level;
  logic                busy_res;
  logic                keys_valid;
  logic [KEYS_W-1:0]   keys;
  logic                cfg_valid    = 1'b0;
  logic                cfg_ready;
  logic [HALF_W-1:0]   cfg_data     = '0;

  int                  fail_count;
  int                  outstanding;
  logic                seq_active;

  int                  cycles       = 0;
  // Set by the item sender, read by the result receiver. quiet switches off the
  // random idling on both sides; long_hold_req asks for one long result hold-off.
  bit                  quiet        = 1'b0;
  bit                  long_hold_req = 1'b0;

  three_wire_serial_master dut (.*);
  tws_link_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or a result goes missing.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one item and wait until it has been accepted. Occasionally the sender
  // idles first, so gaps land on every phase of a transfer.
  task automatic send_item(input logic [1:0] a, input logic [7:0] c, input logic s);
    if (!quiet && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= a;
    cmd_byte   <= c;
    dio_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering items until every predicted line state has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic pick_sample(input samp_mode_t m);
    case (m)
      SAMP_LOW:  return 1'b0;
      SAMP_HIGH: return 1'b1;
      default:   return 1'($urandom_range(1));
    endcase
  endfunction

  // Tick the link until the sequencer is idle. The checker's busy flag lags one
  // item behind while items flow, so the final decision is taken after a drain,
  // when the flag is exact.
  task automatic settle(input samp_mode_t m);
    do begin
      do begin
        send_item(ACT_TICK, 8'($urandom_range(255)), pick_sample(m));
      end while (seq_active);
      drain();
    end while (seq_active);
  endtask

  task automatic write_half(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic. While the link is idle most items start a write or a key
  // read with random content; while it is busy most items are plain ticks, with
  // a few stray commands that the block has to ignore. hold_at marks the item at
  // which the receiver is asked for its long hold-off, and the quiet window is a
  // stretch of items with no idling on either side.
  task automatic random_items(input int n, input int hold_at, input int q_lo,
                              input int q_hi);
    int         pick;
    logic [1:0] a;
    for (int i = 0; i < n; i++) begin
      quiet = (i >= q_lo && i < q_hi);
      if (i == hold_at) long_hold_req = 1'b1;
      pick = $urandom_range(99);
      if (!seq_active) begin
        if (pick < 40)      a = ACT_WRITE;
        else if (pick < 75) a = ACT_READ;
        else if (pick < 85) a = ACT_PARK;
        else                a = ACT_TICK;
      end else begin
        a = (pick < 92) ? ACT_TICK : 2'($urandom_range(1, 3));
      end
      send_item(a, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
    quiet = 1'b0;
  endtask

  // Result side: random stalls about one cycle in ten, none during the quiet
  // window, and one long hold-off on request. During the hold-off the sender keeps
  // offering items, so the block fills up and must stall its item input.
  initial begin : receiver
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (long_hold_req && !held) begin
        held      = 1'b1;
        hold_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 10);
      end
    end
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset half period of one tick.
    // A plain tick and a park on an idle link.
    send_item(ACT_TICK, 8'h00, 1'b1);
    send_item(ACT_PARK, 8'hFF, 1'b0);
    // Byte writes of all zeros and all ones.
    send_item(ACT_WRITE, 8'h00, 1'b0);
    settle(SAMP_LOW);
    send_item(ACT_WRITE, 8'hFF, 1'b1);
    settle(SAMP_HIGH);
    // A key read of all ones; the data line stays released afterwards, and a
    // park on the idle link must leave it released.
    send_item(ACT_READ, 8'h00, 1'b1);
    settle(SAMP_HIGH);
    send_item(ACT_PARK, 8'h5A, 1'b1);
    send_item(ACT_TICK, 8'h00, 1'b0);
    // A key read of all zeros with every command thrown at the busy link.
    send_item(ACT_READ, 8'hC3, 1'b0);
    send_item(ACT_WRITE, 8'h81, 1'b0);
    send_item(ACT_READ, 8'h7E, 1'b0);
    send_item(ACT_PARK, 8'h18, 1'b0);
    settle(SAMP_LOW);
    // A write takes the data line back, then a read of random key bits.
    send_item(ACT_WRITE, 8'hA5, 1'b0);
    settle(SAMP_RAND);
    send_item(ACT_READ, 8'h3C, 1'b1);
    settle(SAMP_RAND);

    // Two ticks per half period.
    write_half(8'd2);
    random_items(200, -1, 0, 0);
    settle(SAMP_RAND);

    // A zero half period behaves like one tick.
    write_half(8'd0);
    random_items(150, -1, 0, 0);
    settle(SAMP_RAND);

    // A long half period: one byte write with stray commands while the long
    // delays count down.
    write_half(8'd12);
    send_item(ACT_WRITE, 8'($urandom_range(255)), 1'b0);
    send_item(ACT_READ, 8'h00, 1'b1);
    send_item(ACT_PARK, 8'h00, 1'b0);
    send_item(ACT_WRITE, 8'hFF, 1'b1);
    settle(SAMP_RAND);

    // Back to one tick: a quiet stretch, then the long receiver hold-off while
    // items keep coming, then a pause until every result is back.
    write_half(8'd1);
    random_items(350, 250, 60, 200);
    drain();
    random_items(40, -1, 0, 0);
    settle(SAMP_RAND);

    write_half(8'd3);
    random_items(120, -1, 0, 0);
    settle(SAMP_RAND);

    write_half(8'($urandom_range(4, 7)));
    random_items(100, -1, 0, 0);

    // Wait for the last results, then idle on to catch anything stray.
    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/tws_pkg.sv
sv/tws_seq.sv
sv/three_wire_serial_master.sv
dv/tws_link_checker.sv
dv/tb_top.sv
